### sv/nihm3_pkg.sv
// ----------------------------------------------------------------------------
// nihm3_pkg: shared types and constants of the identifier hash unit
// Mixing constants, byte-count codes and the queue entry that carries a
// classified, pre-mixed item from the front end to the hash engine.
// ----------------------------------------------------------------------------
package nihm3_pkg;

    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] MIX_ADD   = 32'he6546b64;
    localparam logic [31:0] FIN_M1    = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2    = 32'hc2b2ae35;
    localparam logic [31:0] KNUTH_MUL = 32'd2654435761;

    // Stream widths on the ports.
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    // How much of a byte-string word takes part in the mix.
    localparam logic [1:0] NB_NONE    = 2'd0;
    localparam logic [1:0] NB_PARTIAL = 2'd1;
    localparam logic [1:0] NB_FULL    = 2'd2;

    // Depth of the queue between front end and hash engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        numeric;   // numeric identifier, k holds the final hash
        logic        first;
        logic        last;
        logic [1:0]  nb_code;
        logic [31:0] k;         // pre-mixed word or Knuth product
        logic [31:0] length;
    } queue_entry_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        rotl15 = {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        rotl13 = {v[18:0], v[31:19]};
    endfunction

endpackage

### sv/nihm3_front.sv
// ----------------------------------------------------------------------------
// nihm3_front: input front end
// Accepts one item, classifies it, masks the valid bytes and runs the
// state-free multiplications before handing the item to the queue.
// ----------------------------------------------------------------------------
module nihm3_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [nihm3_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic [nihm3_pkg::IN_USER_W-1:0]       s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  push,
    output nihm3_pkg::queue_entry_t               push_entry,
    input  logic                                  queue_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic        numeric_reg, numeric_next;
    logic        first_reg, first_next;
    logic        last_reg, last_next;
    logic [1:0]  nb_code_reg, nb_code_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] k_reg, k_next;

    logic        accept;
    logic [31:0] in_word;
    logic [2:0]  in_nb;
    logic [31:0] byte_mask;
    logic [1:0]  in_nb_code;
    logic [31:0] mul_factor;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_word       = s_axis_tdata[31:0];
    assign in_nb         = s_axis_tdata[34:32];

    always_comb
    begin
        case (in_nb)
            3'd0:
            begin
                byte_mask  = 32'h0000_0000;
                in_nb_code = nihm3_pkg::NB_NONE;
            end
            3'd1:
            begin
                byte_mask  = 32'h0000_00ff;
                in_nb_code = nihm3_pkg::NB_PARTIAL;
            end
            3'd2:
            begin
                byte_mask  = 32'h0000_ffff;
                in_nb_code = nihm3_pkg::NB_PARTIAL;
            end
            3'd3:
            begin
                byte_mask  = 32'h00ff_ffff;
                in_nb_code = nihm3_pkg::NB_PARTIAL;
            end
            default:
            begin
                // Four or more bytes count as a full word.
                byte_mask  = 32'hffff_ffff;
                in_nb_code = nihm3_pkg::NB_FULL;
            end
        endcase
    end

    assign mul_factor = numeric_reg ? nihm3_pkg::KNUTH_MUL : nihm3_pkg::MIX_C1;

    always_comb
    begin
        state_next   = state_reg;
        numeric_next = numeric_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        nb_code_next = nb_code_reg;
        word_next    = word_reg;
        length_next  = length_reg;
        k_next       = k_reg;
        push         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    numeric_next = ~s_axis_tuser[0];
                    first_next   = s_axis_tuser[1];
                    last_next    = s_axis_tlast;
                    nb_code_next = in_nb_code;
                    word_next    = s_axis_tuser[0] ? (in_word & byte_mask) : in_word;
                    length_next  = s_axis_tdata[66:35];
                    state_next   = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                k_next     = word_reg * mul_factor;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (!numeric_reg)
                begin
                    k_next = nihm3_pkg::rotl15(k_reg) * nihm3_pkg::MIX_C2;
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!queue_full)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign push_entry.numeric = numeric_reg;
    assign push_entry.first   = first_reg;
    assign push_entry.last    = last_reg;
    assign push_entry.nb_code = nb_code_reg;
    assign push_entry.k       = k_reg;
    assign push_entry.length  = length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        numeric_reg <= numeric_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        nb_code_reg <= nb_code_next;
        word_reg    <= word_next;
        length_reg  <= length_next;
        k_reg       <= k_next;
    end

endmodule

### sv/nihm3_fifo.sv
// ----------------------------------------------------------------------------
// nihm3_fifo: item queue
// Short first-in first-out queue of classified items between the front end
// and the hash engine.
// ----------------------------------------------------------------------------
module nihm3_fifo
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  nihm3_pkg::queue_entry_t  wr_data,
    output logic                     full,
    input  logic                     rd_en,
    output nihm3_pkg::queue_entry_t  rd_data,
    output logic                     empty
);

    nihm3_pkg::queue_entry_t entry_reg [nihm3_pkg::QUEUE_DEPTH];

    logic [nihm3_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nihm3_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nihm3_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full    = (count_reg == nihm3_pkg::QUEUE_CNT_W'(nihm3_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == nihm3_pkg::QUEUE_PTR_W'(nihm3_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == nihm3_pkg::QUEUE_PTR_W'(nihm3_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/nihm3_back.sv
// ----------------------------------------------------------------------------
// nihm3_back: hash engine
// Folds queued words into the running hash, latches the string length and
// runs the finalizer through states FIN1 and FIN2 into the output register.
// ----------------------------------------------------------------------------
module nihm3_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  queue_empty,
    input  nihm3_pkg::queue_entry_t               pop_entry,
    output logic                                  pop,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [nihm3_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIN1 = 2'd1;
    localparam logic [1:0] ST_FIN2 = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] saved_reg, saved_next;
    logic [31:0] fin_reg, fin_next;
    logic [31:0] out_reg, out_next;

    logic [31:0] h_start;
    logic [31:0] h_xor;
    logic [31:0] h_rot;
    logic [31:0] h_mixed;
    logic [31:0] saved_sel;
    logic [31:0] fin_in;
    logic [31:0] prod;

    assign h_start   = pop_entry.first ? pop_entry.length : hash_reg;
    assign saved_sel = pop_entry.first ? pop_entry.length : saved_reg;
    assign h_xor     = h_start ^ pop_entry.k;
    assign h_rot     = nihm3_pkg::rotl13(h_xor);

    always_comb
    begin
        case (pop_entry.nb_code)
            nihm3_pkg::NB_FULL:    h_mixed = {h_rot[29:0], 2'b00} + h_rot + nihm3_pkg::MIX_ADD;
            nihm3_pkg::NB_PARTIAL: h_mixed = h_xor;
            default:               h_mixed = h_start;
        endcase
    end

    assign fin_in = h_mixed ^ saved_sel;
    assign prod   = fin_reg * ((state_reg == ST_FIN1) ? nihm3_pkg::FIN_M1 : nihm3_pkg::FIN_M2);

    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        saved_next = saved_reg;
        fin_next   = fin_reg;
        out_next   = out_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    if (pop_entry.numeric)
                    begin
                        // Numeric identifiers leave the stream state alone.
                        out_next   = pop_entry.k;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        hash_next  = h_mixed;
                        saved_next = saved_sel;
                        if (pop_entry.last)
                        begin
                            fin_next   = fin_in ^ {16'h0000, fin_in[31:16]};
                            state_next = ST_FIN1;
                        end
                    end
                end
            end
            ST_FIN1:
            begin
                fin_next   = prod ^ {13'h0000, prod[31:13]};
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                out_next   = prod ^ {16'h0000, prod[31:16]};
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hash_reg  <= '0;
            saved_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            saved_reg <= saved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
        out_reg <= out_next;
    end

endmodule

### sv/node_id_hash_murmur3.sv
// ----------------------------------------------------------------------------
// node_id_hash_murmur3: identifier hash unit
// Knuth multiplicative hash for numeric identifiers and a 32-bit murmur
// style hash for byte-string identifiers streamed as little-endian words.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: word[31:0], valid_bytes[34:32], total_length[66:35]
//                tuser: command[0], first[1]   tlast: last
// m_axis    out  tdata: hash_value[31:0]
//
// The front end works on one item at a time: it accepts the item, runs the two
// multiplications of the word pre-mix, then enters it into the queue once there
// is room. The hash engine folds each popped word into the running hash; a
// string's last word then passes through the finalizer states FIN1 and FIN2,
// after which the hash waits in the output register until taken.
// A numeric item goes to the output register in the cycle it is popped.
// Reset clears the running hash and the latched length. A stall at the
// output lets the two-entry queue fill, and only then is the input stalled.
//
module node_id_hash_murmur3
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // word, valid_bytes, total_length, zero fill
    input  logic [nihm3_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // command, first
    input  logic [nihm3_pkg::IN_USER_W-1:0]       s_axis_tuser,
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // hash_value
    output logic [nihm3_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    // Classified, pre-mixed items travel from the front end to the engine
    // through the queue, so either side can stall on its own.
    nihm3_pkg::queue_entry_t push_entry;
    nihm3_pkg::queue_entry_t pop_entry;
    logic                    push;
    logic                    pop;
    logic                    queue_full;
    logic                    queue_empty;

    nihm3_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_entry    (push_entry),
        .queue_full    (queue_full)
    );

    nihm3_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_entry),
        .full    (queue_full),
        .rd_en   (pop),
        .rd_data (pop_entry),
        .empty   (queue_empty)
    );

    // The engine holds the running hash and the length of the string in
    // progress; each completed identifier becomes one transfer on m_axis.
    nihm3_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### sv/nihm3_chk.sv
// ----------------------------------------------------------------------------
// nihm3_chk: port checker of the identifier hash unit
// Watches the stream ports for handshake and pacing faults.
// ----------------------------------------------------------------------------
module nihm3_chk
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [nihm3_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds its value.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    // The front end works on one item at a time.
    property p_one_in_flight;
        @(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("input taken on consecutive cycles");

    // After a result transfer the engine goes back to fetch the next item.
    property p_out_gap;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid;
    endproperty
    a_out_gap: assert property (p_out_gap) else $error("results on consecutive cycles");

    // After a transfer the front end stays busy through the two multiplies and
    // the queue write.
    property p_in_spacing;
        @(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready [*3];
    endproperty
    a_in_spacing: assert property (p_in_spacing)
        else $error("input taken again too soon after a transfer");

endmodule

bind node_id_hash_murmur3 nihm3_chk u_nihm3_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the identifier hash unit
// A short table of directed items (numeric extremes, empty and null strings,
// partial and oversized words, orphan continuation words, mismatched lengths)
// is followed by about two thousand random items. Most of them are
// well-formed byte strings with numeric items mixed in. Every accepted item
// runs through an independent model of the hash, and each returned hash is
// compared with the oldest expected one. Both stream sides idle in random
// bursts, and the output holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

    // Hash constants, kept here so the prediction does not lean on the RTL.
    localparam logic [31:0] BLK_C1   = 32'hcc9e2d51;
    localparam logic [31:0] BLK_C2   = 32'h1b873593;
    localparam logic [31:0] BLK_ADD  = 32'he6546b64;
    localparam logic [31:0] FMIX_M1  = 32'h85ebca6b;
    localparam logic [31:0] FMIX_M2  = 32'hc2b2ae35;
    localparam logic [31:0] KNUTH_K  = 32'd2654435761;

    localparam int TOTAL_ITEMS    = 2000;
    localparam int QUIET_ITEMS    = 200;   // last stretch of the run runs without idling
    localparam int PHASE_ITEMS    = 250;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int HOLDOFF_AFTER  = 100;   // hashes taken before the long hold-off
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic
    {
        CMD_NUMERIC = 1'b0,
        CMD_STRING  = 1'b1
    } id_cmd_t;

    // One input item. When has_known is set, known_hash is the hash the
    // block must return, read straight off the definition.
    typedef struct packed
    {
        id_cmd_t     command;
        logic [31:0] word;
        logic [2:0]  valid_bytes;
        logic        first;
        logic        last;
        logic [31:0] total_length;
        logic        has_known;
        logic [31:0] known_hash;
    } id_item_t;

    localparam int DIRECTED_COUNT = 23;
    localparam id_item_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Numeric identifiers: zero, one, all ones (other fields ignored), top bit.
        '{CMD_NUMERIC, 32'h00000000, 3'd0, 1'b0, 1'b0, 32'h00000000, 1'b1, 32'h00000000},
        '{CMD_NUMERIC, 32'h00000001, 3'd0, 1'b0, 1'b0, 32'h00000000, 1'b1, 32'h9e3779b1},
        '{CMD_NUMERIC, 32'hffffffff, 3'd7, 1'b1, 1'b1, 32'hffffffff, 1'b1, 32'h61c8864f},
        '{CMD_NUMERIC, 32'h80000000, 3'd0, 1'b0, 1'b0, 32'h00000000, 1'b1, 32'h80000000},
        // Empty string, then a null string whose word carries junk.
        '{CMD_STRING,  32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000, 1'b1, 32'h00000000},
        '{CMD_STRING,  32'h12345678, 3'd0, 1'b1, 1'b1, 32'h00000000, 1'b1, 32'h00000000},
        // A last word with no first before it continues from the running hash.
        '{CMD_STRING,  32'hffffffff, 3'd4, 1'b0, 1'b1, 32'h00000000, 1'b0, 32'h0},
        // Ten-byte string with a numeric item in the middle; the partial
        // last word carries bytes beyond its count that must be masked.
        '{CMD_STRING,  32'hffffffff, 3'd4, 1'b1, 1'b0, 32'd10,       1'b0, 32'h0},
        '{CMD_NUMERIC, 32'h000000ff, 3'd0, 1'b0, 1'b0, 32'h00000000, 1'b0, 32'h0},
        '{CMD_STRING,  32'h00000000, 3'd4, 1'b0, 1'b0, 32'd10,       1'b0, 32'h0},
        '{CMD_STRING,  32'hdeadbeef, 3'd2, 1'b0, 1'b1, 32'd10,       1'b0, 32'h0},
        // Single-word strings of three and one bytes.
        '{CMD_STRING,  32'h00abcdef, 3'd3, 1'b1, 1'b1, 32'd3,        1'b0, 32'h0},
        '{CMD_STRING,  32'h000000ff, 3'd1, 1'b1, 1'b1, 32'd1,        1'b0, 32'h0},
        // Byte count above four counts as a full word; largest length.
        '{CMD_STRING,  32'h80000000, 3'd7, 1'b1, 1'b1, 32'hffffffff, 1'b0, 32'h0},
        // A partial word before the last one gets the tail mix and the
        // stream goes on from there.
        '{CMD_STRING,  32'ha5a5a5a5, 3'd5, 1'b1, 1'b0, 32'd11,       1'b0, 32'h0},
        '{CMD_STRING,  32'h5a5a5a5a, 3'd2, 1'b0, 1'b0, 32'd11,       1'b0, 32'h0},
        '{CMD_STRING,  32'h0f0f0f0f, 3'd6, 1'b0, 1'b1, 32'd11,       1'b0, 32'h0},
        // Declared length that does not match the bytes sent.
        '{CMD_STRING,  32'h13579bdf, 3'd4, 1'b1, 1'b0, 32'd0,        1'b0, 32'h0},
        '{CMD_STRING,  32'h2468ace0, 3'd1, 1'b0, 1'b1, 32'd0,        1'b0, 32'h0},
        // No bytes but a nonzero length: the seed alone is finalized.
        '{CMD_STRING,  32'h00000000, 3'd0, 1'b1, 1'b1, 32'd5,        1'b0, 32'h0},
        '{CMD_STRING,  32'h11223344, 3'd4, 1'b0, 1'b1, 32'd0,        1'b0, 32'h0},
        '{CMD_STRING,  32'hffffffff, 3'd4, 1'b1, 1'b1, 32'd4,        1'b0, 32'h0},
        '{CMD_NUMERIC, 32'h7fffffff, 3'd0, 1'b0, 1'b0, 32'h00000000, 1'b0, 32'h0}
    };

    logic                                clk;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    // word, valid_bytes, total_length, zero fill
    logic [nihm3_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    // command, first
    logic [nihm3_pkg::IN_USER_W-1:0]     s_axis_tuser;
    logic                                s_axis_tlast;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    // hash_value
    logic [nihm3_pkg::OUT_DATA_W-1:0]    m_axis_tdata;

    // Model state of the string hash, starting at zero like the block's after reset.
    logic [31:0] model_running_hash = '0;
    logic [31:0] model_saved_length = '0;

    logic [31:0] pending_hashes [$];

    int items_sent      = 0;
    int numeric_sent    = 0;
    int strings_started = 0;
    int hashes_checked  = 0;
    int mismatch_count  = 0;
    int send_idle_pct   = 0;
    int take_stall_pct  = 0;
    bit quiet_tail      = 1'b0;
    bit holdoff_done    = 1'b0;

    node_id_hash_murmur3 dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Block mix applied to a word before it is folded into the hash.
    function automatic logic [31:0] word_premix(input logic [31:0] k);
        k = k * BLK_C1;
        k = {k[16:0], k[31:17]};
        return k * BLK_C2;
    endfunction

    function automatic logic [31:0] hash_fmix(input logic [31:0] h);
        h = h ^ (h >> 16);
        h = h * FMIX_M1;
        h = h ^ (h >> 13);
        h = h * FMIX_M2;
        return h ^ (h >> 16);
    endfunction

    // Folds one accepted item into the model state. Returns 1 when the item
    // completes an identifier, with its hash in id_hash.
    function automatic bit fold_identifier(input id_item_t it, output logic [31:0] id_hash);
        logic [31:0] h;
        logic [31:0] k;
        logic [2:0]  nb;
        id_hash = '0;
        if (it.command == CMD_NUMERIC)
        begin
            // Numeric identifiers never touch the string state.
            id_hash = it.word * KNUTH_K;
            return 1'b1;
        end
        nb = (it.valid_bytes > 3'd4) ? 3'd4 : it.valid_bytes;
        if (it.first)
        begin
            model_saved_length = it.total_length;
            h = it.total_length;
        end
        else
        begin
            h = model_running_hash;
        end
        if (nb == 3'd4)
        begin
            h = h ^ word_premix(it.word);
            h = {h[18:0], h[31:19]} * 32'd5 + BLK_ADD;
        end
        else if (nb != 3'd0)
        begin
            k = it.word & ((32'h1 << (8 * nb)) - 32'h1);
            h = h ^ word_premix(k);
        end
        model_running_hash = h;
        if (it.last)
        begin
            id_hash = hash_fmix(h ^ model_saved_length);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic id_item_t item_of(input id_cmd_t command, input logic [31:0] word,
                                         input logic [2:0] valid_bytes, input logic first,
                                         input logic last, input logic [31:0] total_length);
        id_item_t it;
        it.command      = command;
        it.word         = word;
        it.valid_bytes  = valid_bytes;
        it.first        = first;
        it.last         = last;
        it.total_length = total_length;
        it.has_known    = 1'b0;
        it.known_hash   = '0;
        return it;
    endfunction

    // Offers one item, possibly after an idle burst, and records the hash it
    // is expected to produce once the transfer happens.
    task automatic send_item(input id_item_t it);
        logic [31:0] predicted;
        if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, it.total_length, it.valid_bytes, it.word};
        s_axis_tuser  <= {it.first, it.command};
        s_axis_tlast  <= it.last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (fold_identifier(it, predicted))
            pending_hashes.push_back(it.has_known ? it.known_hash : predicted);
        items_sent++;
        if (it.command == CMD_NUMERIC)
            numeric_sent++;
    endtask

    // Streams a byte string of n_bytes as little-endian words, with the given
    // declared length. Without finish the final word is not marked last, so
    // the string is abandoned. Numeric items are slipped in now and then.
    task automatic send_string(input int unsigned n_bytes, input logic [31:0] declared,
                               input bit finish);
        int unsigned words;
        int unsigned nb;
        words = (n_bytes == 0) ? 1 : (n_bytes + 3) / 4;
        for (int unsigned i = 0; i < words; i++)
        begin
            if (i > 0 && $urandom_range(0, 9) == 0)
                send_item(item_of(CMD_NUMERIC, $urandom, 3'($urandom_range(0, 7)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  $urandom));
            if (n_bytes == 0)
                nb = 0;
            else if (i == words - 1 && n_bytes % 4 != 0)
                nb = n_bytes % 4;
            else
                nb = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : 4;
            send_item(item_of(CMD_STRING, $urandom, nb[2:0], i == 0,
                              finish && (i == words - 1), declared));
        end
        strings_started++;
    endtask

    // Output side: random stall bursts, plus one long hold-off that lets
    // the internal queue fill so the input has to stall as well.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && hashes_checked >= HOLDOFF_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 99) < take_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Result checker: every hash transfer must match the oldest prediction.
    always @(posedge clk)
    begin
        logic [31:0] wanted;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $display("%0t: hash %08h returned while none expected", $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                wanted = pending_hashes.pop_front();
                if (m_axis_tdata !== wanted)
                begin
                    $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                             $time, wanted, m_axis_tdata);
                    mismatch_count++;
                end
                hashes_checked++;
            end
        end
    end

    // Watchdog: cycles in a row with no transfer on either side.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transfer for %0d cycles, %0d hashes still expected",
                 $time, WATCHDOG_LIMIT, pending_hashes.size());
        $display("tb failed");
        $finish;
    end

    // Stimulus: directed table first, then random phases.
    initial
    begin
        int          next_phase;
        int unsigned n_bytes;
        int unsigned pick;
        logic [31:0] declared;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The directed table runs with light idling on both sides.
        send_idle_pct  = 20;
        take_stall_pct = 20;
        for (int r = 0; r < DIRECTED_COUNT; r++)
            send_item(DIRECTED_ROWS[r]);

        next_phase = items_sent;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS)
            begin
                quiet_tail = 1'b1;
            end
            else if (items_sent >= next_phase)
            begin
                // Each phase picks its own idling; zero gives stretches with none.
                pick = $urandom_range(0, 2);
                send_idle_pct  = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
                pick = $urandom_range(0, 2);
                take_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 40;
                next_phase = items_sent + PHASE_ITEMS;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_item(item_of(CMD_NUMERIC, $urandom, 3'($urandom_range(0, 7)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  $urandom));
            end
            else if (pick < 16)
            begin
                // Noise: any combination of flags, counts and lengths.
                send_item(item_of(id_cmd_t'($urandom_range(0, 1)), $urandom,
                                  3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), $urandom));
            end
            else
            begin
                n_bytes  = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 160)
                                                        : $urandom_range(0, 24);
                declared = ($urandom_range(0, 9) == 0) ? $urandom : n_bytes;
                send_string(n_bytes, declared, pick >= 20);
            end
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d numeric, %0d byte strings begun, with idling and one long",
                 items_sent, numeric_sent, strings_started);
        $display("output hold-off; %0d hashes compared, %0d mismatches.",
                 hashes_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### sim.f
sv/nihm3_pkg.sv
sv/nihm3_front.sv
sv/nihm3_fifo.sv
sv/nihm3_back.sv
sv/node_id_hash_murmur3.sv
sv/nihm3_chk.sv
verif/tb.sv
